/* sv/hrt_pkg.sv */
`timescale 1ns / 1ps
package hrt_pkg;

  localparam int unsigned LenBits = 16;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } req_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [2:0]  event_res;
    logic [3:0]  method_code;
    logic        version_code;
    logic [2:0]  error_code;
    logic [15:0] name_length;
    logic [15:0] value_length;
    logic [15:0] header_index;
    logic        is_length_header;
    logic [31:0] clen_value;
  } res_t;

  typedef enum logic [12:0] {
    PhLead    = 13'b0000000000001,
    PhMethod  = 13'b0000000000010,
    PhGap1    = 13'b0000000000100,
    PhPath    = 13'b0000000001000,
    PhQuery   = 13'b0000000010000,
    PhGap2    = 13'b0000000100000,
    PhVersion = 13'b0000001000000,
    PhHlead   = 13'b0000010000000,
    PhName    = 13'b0000100000000,
    PhValue   = 13'b0001000000000,
    PhBody    = 13'b0010000000000,
    PhDone    = 13'b0100000000000,
    PhError   = 13'b1000000000000
  } phase_e;

  localparam logic [2:0] RoleNone = 3'd0, RoleMethod = 3'd1, RolePath = 3'd2,
    RoleQuery = 3'd3, RoleVersion = 3'd4, RoleName = 3'd5, RoleValue = 3'd6,
    RoleBody = 3'd7;
  localparam logic [2:0] EvNone = 3'd0, EvStart = 3'd1, EvHeader = 3'd2,
    EvHeadDone = 3'd3, EvMsgDone = 3'd4, EvError = 3'd5;
  localparam logic [2:0] ErrNone = 3'd0, ErrMethod = 3'd1, ErrShort = 3'd2,
    ErrHttp23 = 3'd3, ErrVersion = 3'd4, ErrColon = 3'd5, ErrEmptyName = 3'd6,
    ErrEmptyValue = 3'd7;
  localparam logic [3:0] NoMethod = 4'd15;

  // method keyword char at position p (0 past end)
  function automatic logic [7:0] method_char(input logic [3:0] k, input logic [2:0] p);
    logic [8*7-1:0] s;
    case (k)
      4'd0: s = {"GET", 32'h0};
      4'd1: s = {"HEAD", 24'h0};
      4'd2: s = {"POST", 24'h0};
      4'd3: s = {"PUT", 32'h0};
      4'd4: s = {"DELETE", 8'h0};
      4'd5: s = "CONNECT";
      4'd6: s = "OPTIONS";
      4'd7: s = {"TRACE", 16'h0};
      4'd8: s = {"PATCH", 16'h0};
      default: s = '0;
    endcase
    return s[8*(6-p) +: 8];
  endfunction

  function automatic logic [2:0] method_kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd3: return 3'd3;
      4'd1, 4'd2: return 3'd4;
      4'd4: return 3'd6;
      4'd5, 4'd6: return 3'd7;
      default: return 3'd5;
    endcase
  endfunction

  function automatic logic [7:0] version_char(input logic [1:0] k, input logic [2:0] p);
    logic [63:0] s;
    case (k)
      2'd0: s = "HTTP/1.0";
      2'd1: s = "HTTP/1.1";
      2'd2: s = {"HTTP/2", 16'h0};
      default: s = {"HTTP/3", 16'h0};
    endcase
    return s[8*(7-p) +: 8];
  endfunction

  function automatic logic [7:0] length_char(input logic [3:0] p);
    logic [111:0] s;
    s = "Content-Length";
    return s[8*(13-p) +: 8];
  endfunction

endpackage

/* sv/hrt_stream_if.sv */
`timescale 1ns / 1ps
interface hrt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/http_request_head_tokenizer_top.sv */
`timescale 1ns / 1ps
// Channel | Dir | Word
// req     | in  | data_byte[7:0], first
// res     | out | role, event, method, version, error, lengths, index, clen_value
//
// One byte per cycle while req.ready is high. Each byte is decoded in the cycle it
// is accepted and its result word lands in the output register the same edge, or in the skid if res stalls.
// Output register plus one skid word: req.ready stays high while the skid is empty.
// rst_ni (async, low) puts the parser at start line leading space.
// Stalls on res hold the output word; a word accepted during a stall fills the
// skid and drops req.ready until the output drains.
module http_request_head_tokenizer_top (
  input  logic clk_i,
  input  logic rst_ni,
  hrt_stream_if.sink   req,
  hrt_stream_if.source res
);
  import hrt_pkg::*;

  phase_e phase_q, phase_d;
  logic [8:0]  mcand_q, mcand_d;
  logic [3:0]  vcand_q, vcand_d;
  logic [LenBits-1:0] tpos_q, tpos_d, trim_q, trim_d, nhold_q, nhold_d, qhold_q, qhold_d;
  logic [3:0]  mhold_q, mhold_d;
  logic        vhold_q, vhold_d, cr_q, cr_d, lmatch_q, lmatch_d, lseen_q, lseen_d;
  logic        dstop_q, dstop_d;
  logic [31:0] acc_q, acc_d, body_q, body_d;
  logic [15:0] hcnt_q, hcnt_d;

  // output register + skid
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q, r;

  logic take;
  assign req.ready = !skid_v_q;
  assign take = req.valid && req.ready;
  assign res.valid = out_v_q;
  assign res.payload = out_q;

  logic [7:0] b;
  logic ws, le;
  logic [LenBits-1:0] tinc;
  logic [35:0] mul;
  logic [15:0] capn, capv;

  function automatic logic [15:0] cap16(input logic [LenBits-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  always_comb begin
    logic fresh;
    logic [2:0] ev, err, role;
    logic [LenBits-1:0] on, ov, tp;
    logic [15:0] oi;
    logic oisl;
    b = req.payload.data_byte;
    fresh = req.payload.first;
    phase_d = fresh ? PhLead : phase_q;
    mcand_d = fresh ? 9'h1FF : mcand_q;
    vcand_d = fresh ? 4'hF : vcand_q;
    tpos_d = fresh ? '0 : tpos_q;
    trim_d = fresh ? '0 : trim_q;
    nhold_d = fresh ? '0 : nhold_q;
    qhold_d = fresh ? '0 : qhold_q;
    mhold_d = fresh ? 4'd0 : mhold_q;
    vhold_d = fresh ? 1'b0 : vhold_q;
    lmatch_d = fresh ? 1'b0 : lmatch_q;
    lseen_d = fresh ? 1'b0 : lseen_q;
    dstop_d = fresh ? 1'b0 : dstop_q;
    acc_d = fresh ? '0 : acc_q;
    body_d = fresh ? '0 : body_q;
    hcnt_d = fresh ? '0 : hcnt_q;
    le = (b == 8'h0A) && cr_q && !fresh;
    ws = b inside {8'h20, [8'd9:8'd13]};
    tp = tpos_d;
    tinc = (tp < LenMax) ? tp + 1'b1 : tp;
    mul = {1'b0, acc_d, 3'b0} + {3'b0, acc_d, 1'b0} + 36'(b - 8'h30);
    ev = EvNone; err = ErrNone; role = RoleNone;
    on = '0; ov = '0; oi = '0; oisl = 1'b0;
    case (phase_d)
      PhLead: begin
        if (le) begin ev = EvError; err = ErrShort; phase_d = PhError; end
        else if (!ws) begin
          for (int k = 0; k < 9; k++)
            mcand_d[k] = (b == method_char(4'(k), 3'd0));
          tpos_d = LenBits'(1);
          phase_d = PhMethod; role = RoleMethod;
        end
      end
      PhMethod: begin
        if (ws) begin
          mhold_d = NoMethod;
          for (int k = 0; k < 9; k++)
            if (mcand_d[k] && LenBits'(method_kw_len(4'(k))) == tp) mhold_d = 4'(k);
          phase_d = PhGap1;
        end else begin
          for (int k = 0; k < 9; k++)
            if (tp >= LenBits'(method_kw_len(4'(k))) || method_char(4'(k), tp[2:0]) != b)
              mcand_d[k] = 1'b0;
          tpos_d = tinc; role = RoleMethod;
        end
      end
      PhGap1: begin
        if (le) begin ev = EvError; err = ErrShort; phase_d = PhError; end
        else if (!ws) begin
          if (mhold_d > 4'd8) begin ev = EvError; err = ErrMethod; phase_d = PhError; end
          else if (b == "?") begin nhold_d = '0; tpos_d = '0; phase_d = PhQuery; end
          else begin tpos_d = LenBits'(1); phase_d = PhPath; role = RolePath; end
        end
      end
      PhPath: begin
        if (ws || b == "?") begin
          nhold_d = tp; qhold_d = '0;
          tpos_d = ws ? LenBits'(1) : '0;
          phase_d = ws ? PhGap2 : PhQuery;
        end else begin tpos_d = tinc; role = RolePath; end
      end
      PhQuery: begin
        if (ws) begin qhold_d = tp; tpos_d = LenBits'(1); phase_d = PhGap2; end
        else begin tpos_d = tinc; role = RoleQuery; end
      end
      PhGap2: begin
        if (le) begin
          ev = EvError; phase_d = PhError;
          err = (tp == LenBits'(1)) ? ErrShort : ErrVersion;
        end else if (ws) tpos_d = tinc;
        else begin
          for (int k = 0; k < 4; k++) vcand_d[k] = (b == version_char(2'(k), 3'd0));
          tpos_d = LenBits'(1); phase_d = PhVersion; role = RoleVersion;
        end
      end
      PhVersion: begin
        if (le) begin
          if (vcand_d[0] && tp == LenBits'(8)) vhold_d = 1'b0;
          else if (vcand_d[1] && tp == LenBits'(8)) vhold_d = 1'b1;
          if ((vcand_d[0] || vcand_d[1]) && tp == LenBits'(8)) begin
            ev = EvStart; on = nhold_d; ov = qhold_d;
            phase_d = PhHlead; tpos_d = '0; trim_d = '0;
          end else begin
            ev = EvError; phase_d = PhError;
            err = ((vcand_d[2] || vcand_d[3]) && tp == LenBits'(6)) ? ErrHttp23 : ErrVersion;
          end
        end else begin
          logic [LenBits-1:0] t2;
          logic [LenBits-1:0] t3;
          t2 = tp;
          if (cr_q) begin
            vcand_d = '0;
            t2 = (tp < LenMax) ? tp + 1'b1 : tp;
          end
          t3 = t2;
          if (b != 8'h0D) begin
            for (int k = 0; k < 4; k++)
              if (t2 >= ((k < 2) ? LenBits'(8) : LenBits'(6))
                  || version_char(2'(k), t2[2:0]) != b)
                vcand_d[k] = 1'b0;
            t3 = (t2 < LenMax) ? t2 + 1'b1 : t2;
            role = RoleVersion;
          end
          tpos_d = t3;
        end
      end
      PhHlead, PhName: begin
        if (le && phase_d == PhHlead) begin
          body_d = lseen_d ? acc_d : '0;
          ev = (body_d != 0) ? EvHeadDone : EvMsgDone;
          phase_d = (body_d != 0) ? PhBody : PhDone;
        end else if (le) begin ev = EvError; err = ErrColon; phase_d = PhError; end
        else if (!ws || phase_d == PhName) begin
          logic [LenBits-1:0] p;
          logic [LenBits-1:0] tr;
          logic lm;
          p = (phase_d == PhHlead) ? '0 : tp;
          tr = (phase_d == PhHlead) ? '0 : trim_d;
          lm = (phase_d == PhHlead) ? 1'b1 : lmatch_d;
          phase_d = PhName;
          if (b == ":") begin
            if (tr == '0) begin ev = EvError; err = ErrEmptyName; phase_d = PhError; end
            else begin
              nhold_d = tr;
              lm = lm && (tr == LenBits'(14));
              if (lm && !lseen_d) begin acc_d = '0; dstop_d = 1'b0; end
              phase_d = PhValue; tpos_d = '0; trim_d = '0;
            end
            lmatch_d = lm;
          end else begin
            if (p < LenBits'(14) && length_char(p[3:0]) != b) lm = 1'b0;
            p = (p < LenMax) ? p + 1'b1 : p;
            tpos_d = p; trim_d = tr;
            if (!ws) begin trim_d = p; role = RoleName; end
            lmatch_d = lm;
          end
        end
      end
      PhValue: begin
        if (le) begin
          if (trim_d == '0) begin ev = EvError; err = ErrEmptyValue; phase_d = PhError; end
          else begin
            oisl = lmatch_d;
            if (lmatch_d) lseen_d = 1'b1;
            ev = EvHeader; on = nhold_d; ov = trim_d; oi = hcnt_d;
            if (hcnt_d != 16'hFFFF) hcnt_d = hcnt_d + 1'b1;
            phase_d = PhHlead; tpos_d = '0; trim_d = '0; lmatch_d = 1'b0;
          end
        end else if (tp != '0 || !ws) begin
          tpos_d = tinc;
          if (!ws) begin trim_d = tinc; role = RoleValue; end
          if (lmatch_d && !lseen_d && !dstop_d) begin
            if (b inside {["0":"9"]}) acc_d = (mul[35:32] != 0) ? 32'hFFFFFFFF : mul[31:0];
            else dstop_d = 1'b1;
          end
        end
      end
      PhBody: begin
        role = RoleBody;
        body_d = body_d - 1'b1;
        if (body_d == '0) begin ev = EvMsgDone; phase_d = PhDone; end
      end
      default: ;
    endcase
    cr_d = (b == 8'h0D);
    capn = cap16(on);
    capv = cap16(ov);
    r.byte_role = role;
    r.event_res = ev;
    r.method_code = (mhold_d <= 4'd8) ? mhold_d : 4'd0;
    r.version_code = vhold_d;
    r.error_code = err;
    r.name_length = capn;
    r.value_length = capv;
    r.header_index = oi;
    r.is_length_header = oisl;
    r.clen_value = lseen_d ? acc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead; mcand_q <= 9'h1FF; vcand_q <= 4'hF;
      tpos_q <= '0; trim_q <= '0; nhold_q <= '0; qhold_q <= '0;
      mhold_q <= '0; vhold_q <= 1'b0; cr_q <= 1'b0; lmatch_q <= 1'b0;
      lseen_q <= 1'b0; dstop_q <= 1'b0; acc_q <= '0; body_q <= '0; hcnt_q <= '0;
    end else if (take) begin
      phase_q <= phase_d; mcand_q <= mcand_d; vcand_q <= vcand_d;
      tpos_q <= tpos_d; trim_q <= trim_d; nhold_q <= nhold_d; qhold_q <= qhold_d;
      mhold_q <= mhold_d; vhold_q <= vhold_d; cr_q <= cr_d; lmatch_q <= lmatch_d;
      lseen_q <= lseen_d; dstop_q <= dstop_d; acc_q <= acc_d; body_q <= body_d;
      hcnt_q <= hcnt_d;
    end
  end

  // output stage: out register, skid catches a word when out is stalled
  logic out_free;
  assign out_free = !out_v_q || res.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q <= skid_v_q || take;
        skid_v_q <= 1'b0;
      end else if (take) skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) out_q <= skid_v_q ? skid_q : r;
    if (take && (!out_free || skid_v_q)) skid_q <= r;
  end

  ap_skid_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with empty output");
  ap_no_take_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !req.ready) else $error("accepted with skid full");
  ap_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.payload.event_res != EvError) |-> res.payload.error_code == ErrNone)
    else $error("error code without error event");
  ap_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(take) && $past(phase_q) == PhError && !$past(req.payload.first))
    |-> phase_q == PhError) else $error("left error phase without restart");

endmodule
